@@ design/bmhq_pkg.sv @@
`default_nettype none

package bmhq_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ECNT_W   = 7;
    localparam int STAT_W   = 2;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [CNT_W-1:0]        t_count;

    // Operation codes on the op field.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Command broadcast to every cell of the sorted chain.
    typedef struct packed {
        logic ins;
        logic rem;
        t_key key;
    } t_cell_cmd;

    // What a cell hands to its neighbors.
    typedef struct packed {
        logic vld;
        logic lt;
        t_key key;
    } t_cell_link;

endpackage

`default_nettype wire

@@ design/bmhq_req_if.sv @@
`default_nettype none

interface bmhq_req_if
    import bmhq_pkg::*;
();
    logic valid;
    logic ready;
    logic op;
    t_key key_in;

    modport source (output valid, output op, output key_in, input ready);
    modport sink   (input valid, input op, input key_in, output ready);
endinterface

`default_nettype wire

@@ design/bmhq_rsp_if.sv @@
`default_nettype none

interface bmhq_rsp_if
    import bmhq_pkg::*;
();
    logic              valid;
    logic              ready;
    t_key              removed_key;
    t_key              min_key;
    logic              is_empty;
    logic [ECNT_W-1:0] entry_count;
    logic [STAT_W-1:0] status;

    modport source (output valid, output removed_key, output min_key, output is_empty,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input removed_key, input min_key, input is_empty,
                    input entry_count, input status, output ready);
endinterface

`default_nettype wire

@@ design/bmhq_cell.sv @@
`default_nettype none

module bmhq_cell
    import bmhq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_cmd  i_cmd,
    input  wire t_cell_link i_left,
    input  wire t_cell_link i_right,
    output t_cell_link      o_link
);

    logic r_valid;
    logic n_valid;
    t_key r_key;
    t_key n_key;
    logic w_lt;

    // New key belongs at or before this slot.
    assign w_lt = !r_valid || (i_cmd.key < r_key);

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        if (i_cmd.ins) begin
            n_valid = r_valid | i_left.vld;
            if (i_left.lt) begin
                n_key = i_left.key;
            end else if (w_lt) begin
                n_key = i_cmd.key;
            end
        end else if (i_cmd.rem) begin
            n_valid = i_right.vld;
            n_key   = i_right.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_link.vld = r_valid;
    assign o_link.lt  = w_lt;
    assign o_link.key = r_key;

endmodule

`default_nettype wire

@@ design/binary_min_heap_queue.sv @@
// Response: registered; the response word is valid in the cycle after its request word is accepted.
// Throughput: one request word per cycle while the response side is ready; every operation
// completes as each cell of the sorted chain shifts at once.
// Reset: synchronous, active low; empties the queue and drops any pending response.
`default_nettype none

module binary_min_heap_queue
    import bmhq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bmhq_req_if.sink   i_req,
    bmhq_rsp_if.source o_rsp
);

    // The queue is kept as a chain of cells sorted ascending: cell 0 holds
    // the minimum. An insert shifts every cell at or above the insertion
    // point one place right; a remove shifts the whole chain one place left.
    // The same multiset of keys as a binary heap, so minima match exactly.

    t_cell_cmd  w_cmd;
    t_cell_link w_link [CAPACITY];

    t_count            r_count;
    logic              r_out_valid;
    t_key              r_removed;
    logic [STAT_W-1:0] r_status;

    logic w_accept;
    logic w_full;
    logic w_empty;

    // Take a new word whenever the output register is free or being drained.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == t_count'(CAPACITY));
    assign w_empty     = (r_count == '0);

    // Broadcast command; a full insert and an empty remove leave the chain alone.
    assign w_cmd.ins = w_accept && (i_req.op == OP_INSERT) && !w_full;
    assign w_cmd.rem = w_accept && (i_req.op == OP_REMOVE) && !w_empty;
    assign w_cmd.key = i_req.key_in;

    // Build the chain; the ends see fixed neighbors.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_link w_left;
        t_cell_link w_right;

        if (g == 0) begin : g_head
            assign w_left.vld = 1'b1;
            assign w_left.lt  = 1'b0;
            assign w_left.key = '0;
        end else begin : g_mid_l
            assign w_left = w_link[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right.vld = 1'b0;
            assign w_right.lt  = 1'b1;
            assign w_right.key = '0;
        end else begin : g_mid_r
            assign w_right = w_link[g+1];
        end

        bmhq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g])
        );
    end

    // Track the count and load the response word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cmd.ins) begin
                r_count <= r_count + t_count'(1);
            end else if (w_cmd.rem) begin
                r_count <= r_count - t_count'(1);
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the response; hold while stalled since accept needs ready.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (i_req.op == OP_INSERT) begin
                r_removed <= '0;
                r_status  <= w_full ? ST_FULL : ST_OK;
            end else if (w_empty) begin
                r_removed <= -t_key'(1);
                r_status  <= ST_EMPTY;
            end else begin
                r_removed <= w_link[0].key;
                r_status  <= ST_OK;
            end
        end
    end

    // State only moves together with a new response, so the live chain
    // head and count describe the state after the pending word's operation.
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.removed_key = r_removed;
    assign o_rsp.status      = r_status;
    assign o_rsp.min_key     = w_link[0].vld ? w_link[0].key : '0;
    assign o_rsp.is_empty    = w_empty;
    assign o_rsp.entry_count = ECNT_W'(r_count);

endmodule

`default_nettype wire

@@ tb/sv/tb_binary_min_heap_queue.sv @@
`timescale 1ns / 100ps

module tb_binary_min_heap_queue;
    import bmhq_pkg::*;

    // One request word as queued for the driver.
    typedef struct {
        logic op;
        t_key key;
    } t_heap_cmd;

    // One response word, as predicted or as seen on the response channel.
    typedef struct packed {
        t_key              removed_key;
        t_key              min_key;
        logic              is_empty;
        logic [ECNT_W-1:0] entry_count;
        logic [STAT_W-1:0] status;
    } t_heap_result;

    localparam t_key KEY_MIN = 32'sh8000_0000;
    localparam t_key KEY_MAX = 32'sh7FFF_FFFF;

    logic i_clk;
    logic i_rst_n;

    bmhq_req_if req_if ();
    bmhq_rsp_if rsp_if ();

    binary_min_heap_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_heap_cmd    heap_cmds[$];         // request words not yet offered
    t_heap_result expected_results[$];  // predicted response words, oldest first

    // Shadow heap: only entries below shadow_len are ever read.
    t_key shadow_heap[CAPACITY];
    int   shadow_len = 0;

    int mismatches = 0;
    int send_gap   = 0;
    int send_calm  = 0;
    int stall_left = 0;
    int stall_calm = 0;
    t_heap_cmd    next_cmd;
    t_heap_result seen_result;

    // Clock, and known values on every block input from time zero.
    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.op     = OP_INSERT;
        req_if.key_in = '0;
        rsp_if.ready  = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle length between words: mostly none, some short, a few long, and
    // every so often a long calm stretch with no idling at all.
    function automatic int idle_cycles(inout int calm_left);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if (roll < 3) begin
            calm_left = $urandom_range(30, 120);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Key mix: full-range values, boundary values, and a narrow band that
    // makes equal keys common so tie handling gets exercised.
    function automatic t_key pick_key();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2) begin
            case ($urandom_range(0, 4))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return t_key'(0);
                3: return t_key'(-1);
                default: return t_key'(1);
            endcase
        end
        if (roll < 5)
            return t_key'(int'($urandom_range(0, 16)) - 8);
        return t_key'($urandom);
    endfunction

    function automatic t_heap_cmd make_cmd(logic op, t_key key);
        t_heap_cmd c;
        c.op  = op;
        c.key = key;
        return c;
    endfunction

    // Append one request word to the driver's queue.
    function automatic void queue_cmd(logic op, t_key key);
        heap_cmds.insert(heap_cmds.size(), make_cmd(op, key));
    endfunction

    // Apply one operation to the shadow heap and return the response word
    // it must produce. Insert sifts up on strict less-than; remove moves the
    // last entry to the root and sifts down, parent winning ties and the
    // left child winning over the right.
    function automatic t_heap_result apply_heap_op(logic op, t_key key);
        t_heap_result r;
        int   pos;
        int   parent;
        int   lc;
        int   rc;
        int   best;
        t_key tmp;
        r.removed_key = '0;
        r.status      = ST_OK;
        if (op == OP_INSERT) begin
            if (shadow_len >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                shadow_heap[shadow_len] = key;
                pos = shadow_len;
                shadow_len++;
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (shadow_heap[pos] < shadow_heap[parent]) begin
                        tmp                 = shadow_heap[pos];
                        shadow_heap[pos]    = shadow_heap[parent];
                        shadow_heap[parent] = tmp;
                        pos = parent;
                    end else begin
                        break;
                    end
                end
            end
        end else if (shadow_len == 0) begin
            r.removed_key = t_key'(-1);
            r.status      = ST_EMPTY;
        end else begin
            r.removed_key = shadow_heap[0];
            shadow_len--;
            shadow_heap[0] = shadow_heap[shadow_len];
            pos = 0;
            while (1) begin
                lc   = 2 * pos + 1;
                rc   = lc + 1;
                best = pos;
                if (lc >= shadow_len)
                    break;
                if (shadow_heap[best] > shadow_heap[lc])
                    best = lc;
                if (rc < shadow_len && shadow_heap[best] > shadow_heap[rc])
                    best = rc;
                if (best == pos)
                    break;
                tmp               = shadow_heap[pos];
                shadow_heap[pos]  = shadow_heap[best];
                shadow_heap[best] = tmp;
                pos = best;
            end
        end
        r.min_key     = (shadow_len > 0) ? shadow_heap[0] : t_key'(0);
        r.is_empty    = (shadow_len == 0);
        r.entry_count = ECNT_W'(shadow_len);
        return r;
    endfunction

    // Driver: offer the next queued word once the current one is taken,
    // holding valid low for a random gap after each word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            send_gap = 0;
        end else if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
                send_gap--;
                req_if.valid <= 1'b0;
            end else if (heap_cmds.size() > 0) begin
                next_cmd = heap_cmds.pop_front();
                req_if.valid  <= 1'b1;
                req_if.op     <= next_cmd.op;
                req_if.key_in <= next_cmd.key;
                send_gap = idle_cycles(send_calm);
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: predict on every accepted request word first, so a response
    // in the same edge still finds its expectation; then check the response
    // word against the oldest one, and stall the response channel at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (req_if.valid && req_if.ready)
                expected_results.insert(expected_results.size(),
                                        apply_heap_op(req_if.op, req_if.key_in));
            if (rsp_if.valid && rsp_if.ready) begin
                seen_result.removed_key = rsp_if.removed_key;
                seen_result.min_key     = rsp_if.min_key;
                seen_result.is_empty    = rsp_if.is_empty;
                seen_result.entry_count = rsp_if.entry_count;
                seen_result.status      = rsp_if.status;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected response word:", $realtime);
                        $display("    removed %0d min %0d empty %0b count %0d status %0d",
                                 seen_result.removed_key, seen_result.min_key,
                                 seen_result.is_empty, seen_result.entry_count,
                                 seen_result.status);
                    end
                end else begin
                    if (seen_result !== expected_results[0]) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch:", $realtime);
                            $display("    want removed %0d min %0d empty %0b count %0d status %0d",
                                     expected_results[0].removed_key,
                                     expected_results[0].min_key,
                                     expected_results[0].is_empty,
                                     expected_results[0].entry_count,
                                     expected_results[0].status);
                            $display("    got  removed %0d min %0d empty %0b count %0d status %0d",
                                     seen_result.removed_key, seen_result.min_key,
                                     seen_result.is_empty, seen_result.entry_count,
                                     seen_result.status);
                        end
                    end
                    void'(expected_results.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
                stall_left = idle_cycles(stall_calm);
            end
        end
    end

    // Stimulus: directed words, a fill past capacity and a drain past empty,
    // then random segments, some leaning toward insert and some toward remove, so the heap
    // swings between shallow and deep.
    initial begin
        int issued;
        int seg_len;
        int ins_pct;

        // Remove on an empty heap.
        queue_cmd(OP_REMOVE, KEY_MAX);
        // Extremes of the key range, and equal keys.
        queue_cmd(OP_INSERT, t_key'(0));
        queue_cmd(OP_INSERT, t_key'(-1));
        queue_cmd(OP_INSERT, KEY_MAX);
        queue_cmd(OP_INSERT, KEY_MIN);
        queue_cmd(OP_INSERT, KEY_MIN);
        queue_cmd(OP_INSERT, t_key'(7));
        queue_cmd(OP_INSERT, t_key'(7));
        queue_cmd(OP_INSERT, t_key'(1));
        // Drain everything, one remove past empty.
        repeat (9) queue_cmd(OP_REMOVE, t_key'(-1));
        // Single entry in and out, then empty again.
        queue_cmd(OP_INSERT, KEY_MAX);
        queue_cmd(OP_REMOVE, KEY_MIN);
        queue_cmd(OP_REMOVE, t_key'(0));

        // Fill past capacity so the last inserts are dropped, then drain
        // past empty.
        repeat (CAPACITY + 4) queue_cmd(OP_INSERT, pick_key());
        repeat (CAPACITY + 3) queue_cmd(OP_REMOVE, pick_key());
        issued = heap_cmds.size();

        while (issued < 900) begin
            seg_len = $urandom_range(20, 80);
            case ($urandom_range(0, 3))
                0: ins_pct = 15;
                1: ins_pct = 50;
                default: ins_pct = 85;
            endcase
            repeat (seg_len) begin
                if ($urandom_range(0, 99) < ins_pct)
                    queue_cmd(OP_INSERT, pick_key());
                else
                    queue_cmd(OP_REMOVE, pick_key());
            end
            issued += seg_len;
        end

        // Hold reset, then release.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every word is taken and every response has come back.
        while (heap_cmds.size() > 0 || req_if.valid)
            @(posedge i_clk);
        while (expected_results.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
